### hdl/stl_pkg.sv
`default_nettype none

package stl_pkg;

	// Widths and defaults
	localparam int LENGTH_BITS_DEF = 16;
	localparam int LEN_OUT_W       = 16;
	localparam int MAX_RES         = 3;
	localparam int RES_CNT_W       = 2;

	// Characters with a special meaning
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_LC_H  = 8'h68;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_DEC   = 3'd1,
		MODE_BIN   = 3'd2,
		MODE_HEX   = 3'd3,
		MODE_IDENT = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_INT   = 2'd0,
		KIND_TYPE  = 2'd1,
		KIND_IDENT = 2'd2,
		KIND_OP    = 2'd3
	} kind_t;

	localparam logic EV_CHAR = 1'b0;
	localparam logic EV_END  = 1'b1;

	typedef struct packed {
		logic [7:0] ch;
		logic       final_item;
	} in_item_t;

	typedef struct packed {
		logic                 event_res;
		kind_t                kind;
		logic [7:0]           char_out;
		logic [LEN_OUT_W-1:0] token_length;
		logic                 last_of_run;
	} out_item_t;

	// All results caused by one input item
	typedef struct packed {
		logic [RES_CNT_W-1:0]       count;
		out_item_t [MAX_RES-1:0]    slots;
	} res_set_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SPACE, [8'h09:8'h0D]};
	endfunction

	function automatic kind_t kind_of(input mode_t m);
		return (m == MODE_IDENT) ? KIND_IDENT : KIND_INT;
	endfunction

	function automatic out_item_t mk_char(input kind_t k, input logic [7:0] c);
		out_item_t r;
		r.event_res    = EV_CHAR;
		r.kind         = k;
		r.char_out     = c;
		r.token_length = '0;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	function automatic out_item_t mk_end(input kind_t k, input logic [LEN_OUT_W-1:0] len);
		out_item_t r;
		r.event_res    = EV_END;
		r.kind         = k;
		r.char_out     = CH_NUL;
		r.token_length = len;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/stl_lex_core.sv
`default_nettype none

module stl_lex_core #(
	parameter int LengthBits = stl_pkg::LENGTH_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  stl_pkg::in_item_t    item,
	input  wire                  step,
	output stl_pkg::res_set_t    res
);

	localparam int ExtW = LengthBits + stl_pkg::LEN_OUT_W;
	localparam logic [stl_pkg::LEN_OUT_W-1:0] LenMax = '1;

	stl_pkg::mode_t          mode_q, mode_d;
	logic [LengthBits-1:0]   count_q, count_d, count_inc;
	logic                    ended_q, ended_d;
	logic [stl_pkg::LEN_OUT_W-1:0] len_cur, len_inc;
	logic [ExtW-1:0]         ext_cur, ext_inc;
	logic                    cont, dec_b, starts, drop;
	stl_pkg::kind_t          cont_kind;
	stl_pkg::mode_t          start_mode;
	logic [stl_pkg::RES_CNT_W-1:0] n;
	logic [7:0]              c;

	assign c = item.ch;

	// Saturating count and reported lengths
	always_comb begin
		count_inc = (count_q == '1) ? count_q : count_q + LengthBits'(1);
		ext_cur   = ExtW'(count_q);
		ext_inc   = ExtW'(count_inc);
		len_cur   = (ext_cur > ExtW'(LenMax)) ? LenMax : ext_cur[stl_pkg::LEN_OUT_W-1:0];
		len_inc   = (ext_inc > ExtW'(LenMax)) ? LenMax : ext_inc[stl_pkg::LEN_OUT_W-1:0];
	end

	// Classify the byte against the open token
	always_comb begin
		dec_b     = 1'b0;
		cont      = 1'b0;
		cont_kind = stl_pkg::KIND_INT;
		case (mode_q)
			stl_pkg::MODE_DEC: begin
				dec_b = (c == stl_pkg::CH_LC_B) || (c == stl_pkg::CH_UC_B);
				cont  = stl_pkg::is_digit(c) || (c == stl_pkg::CH_DOT) || dec_b;
				cont_kind = dec_b ? stl_pkg::KIND_TYPE : stl_pkg::KIND_INT;
			end
			stl_pkg::MODE_BIN: begin
				cont = (c == stl_pkg::CH_ZERO) || (c == stl_pkg::CH_ONE);
			end
			stl_pkg::MODE_HEX: begin
				cont = stl_pkg::is_xdigit(c);
			end
			stl_pkg::MODE_IDENT: begin
				cont = stl_pkg::is_alpha(c) || stl_pkg::is_digit(c) ||
					(c == stl_pkg::CH_UNDER);
				cont_kind = stl_pkg::KIND_IDENT;
			end
			default: begin
				cont = 1'b0;
			end
		endcase

		drop       = stl_pkg::is_space(c) || (c == stl_pkg::CH_UNDER);
		starts     = 1'b1;
		start_mode = stl_pkg::MODE_IDENT;
		if (stl_pkg::is_digit(c)) begin
			start_mode = stl_pkg::MODE_DEC;
		end else if (c == stl_pkg::CH_LC_B) begin
			start_mode = stl_pkg::MODE_BIN;
		end else if (c == stl_pkg::CH_LC_H) begin
			start_mode = stl_pkg::MODE_HEX;
		end else if (!stl_pkg::is_alpha(c)) begin
			starts = 1'b0;
		end
	end

	// Build the result list and the next state
	always_comb begin
		res     = '0;
		n       = '0;
		mode_d  = mode_q;
		count_d = count_q;
		ended_d = ended_q;
		if (!ended_q) begin
			if (c == stl_pkg::CH_NUL) begin
				// end of text: close what is open
				if (mode_q != stl_pkg::MODE_IDLE) begin
					res.slots[n] = stl_pkg::mk_end(stl_pkg::kind_of(mode_q), len_cur);
					n = n + 2'd1;
				end
				mode_d  = stl_pkg::MODE_IDLE;
				count_d = '0;
				ended_d = 1'b1;
			end else if (cont) begin
				// extend the open token
				res.slots[n] = stl_pkg::mk_char(cont_kind, c);
				n = n + 2'd1;
				count_d = count_inc;
				if (dec_b || item.final_item) begin
					res.slots[n] = stl_pkg::mk_end(
						dec_b ? stl_pkg::KIND_TYPE : stl_pkg::kind_of(mode_q), len_inc);
					n = n + 2'd1;
					mode_d  = stl_pkg::MODE_IDLE;
					count_d = '0;
				end
				ended_d = item.final_item;
			end else begin
				// terminate the open token, then take the byte afresh
				if (mode_q != stl_pkg::MODE_IDLE) begin
					res.slots[n] = stl_pkg::mk_end(stl_pkg::kind_of(mode_q), len_cur);
					n = n + 2'd1;
				end
				mode_d  = stl_pkg::MODE_IDLE;
				count_d = '0;
				if (drop) begin
					mode_d = stl_pkg::MODE_IDLE;
				end else if (starts) begin
					res.slots[n] = stl_pkg::mk_char(stl_pkg::kind_of(start_mode), c);
					n = n + 2'd1;
					mode_d  = start_mode;
					count_d = LengthBits'(1);
					if (item.final_item) begin
						res.slots[n] = stl_pkg::mk_end(stl_pkg::kind_of(start_mode),
							stl_pkg::LEN_OUT_W'(1));
						n = n + 2'd1;
						mode_d  = stl_pkg::MODE_IDLE;
						count_d = '0;
					end
				end else begin
					// one-byte operator
					res.slots[n] = stl_pkg::mk_char(stl_pkg::KIND_OP, c);
					n = n + 2'd1;
					res.slots[n] = stl_pkg::mk_end(stl_pkg::KIND_OP, stl_pkg::LEN_OUT_W'(1));
					n = n + 2'd1;
				end
				ended_d = item.final_item;
			end
		end
		res.count = n;
	end

	// Advance the lexer state on each consumed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stl_pkg::MODE_IDLE;
			count_q <= '0;
			ended_q <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			ended_q <= ended_d;
		end
	end

endmodule

`default_nettype wire

### hdl/stl_res_buf.sv
`default_nettype none

module stl_res_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  stl_pkg::res_set_t    res,
	output logic                 can_load,
	input  wire                  load,
	output logic                 result_valid,
	input  wire                  result_ready,
	output stl_pkg::out_item_t   result
);

	stl_pkg::out_item_t [stl_pkg::MAX_RES-1:0] slots_q;
	logic [stl_pkg::RES_CNT_W-1:0]             cnt_q;
	logic                                      xfer;

	assign result_valid = (cnt_q != '0);
	assign xfer         = result_valid && result_ready;
	assign can_load     = (cnt_q == '0) || ((cnt_q == 2'd1) && result_ready);

	// The remaining slot is always the last of its run
	always_comb begin
		result             = slots_q[0];
		result.last_of_run = (cnt_q == 2'd1);
	end

	// Hold the count of pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load a new run or shift forward after each transfer
	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= res.slots;
		end else if (xfer) begin
			slots_q[0] <= slots_q[1];
			slots_q[1] <= slots_q[2];
		end
	end

endmodule

`default_nettype wire

### hdl/script_token_lexer.sv
`default_nettype none

// Streaming tokenizer: one text byte goes in per transfer, and for each byte
// between zero and three results come out in order (an end event for a token
// that the byte terminates, the byte's character event, and an end event for
// a token that the byte completes; end events carry kind and saturating
// length); last_of_run marks the final result caused by a byte. A byte is
// registered, lexed combinationally and its results are loaded into a
// three-entry result buffer, so a new byte is accepted every cycle as long
// as each byte gives at most one result and result_ready stays high; a byte
// that gives two or three results holds the input until its results have
// drained to the last one, since the result port moves one result per cycle.
// A zero byte or a byte marked final closes the text; later bytes are taken
// and dropped until reset. No clearing pass after reset is needed.
module script_token_lexer #(
	parameter int LENGTH_BITS = stl_pkg::LENGTH_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  stl_pkg::in_item_t    item,
	output logic                 result_valid,
	input  wire                  result_ready,
	output stl_pkg::out_item_t   result
);

	stl_pkg::in_item_t  item_s1;
	logic               valid_s1;
	logic               can_load;
	logic               load;
	stl_pkg::res_set_t  res;

	assign load       = valid_s1 && can_load;
	assign item_ready = !valid_s1 || load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	stl_lex_core #(
		.LengthBits(LENGTH_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.step   (load),
		.res    (res)
	);

	stl_res_buf u_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.can_load     (can_load),
		.load         (load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
